// ----- src/mme_pkg.sv -----
// shared types and constants for the matrix multiply engine
package mme_pkg;

   localparam int MAX_DIM_DEFAULT      = 16;
   localparam int ELEMENT_BITS_DEFAULT = 16;

   localparam int DIM_REG_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int IDX_FIELD_W = 4;
   localparam int VALUE_W = 16;
   localparam int SUM_W = 36;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(16);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_LEN = 2'd1,
      CSR_COLS_B    = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic capture;
      logic err;
      logic rd_en;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
   } status_type;

endpackage

// ----- src/mme_ctrl.sv -----
// controller: size registers, item sequencing and result handshake
module mme_ctrl #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT,
   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [1:0]                           req_opcode,
   input  logic [mme_pkg::IDX_FIELD_W-1:0]      req_row,
   input  logic [mme_pkg::IDX_FIELD_W-1:0]      req_col,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mme_pkg::DIM_REG_W-1:0]        csr_wdata,
   output mme_pkg::cmd_type                     cmd,
   output logic [IDX_W-1:0]                     rd_index,
   input  mme_pkg::status_type                  status
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [mme_pkg::DIM_REG_W-1:0] rows_a_ff, rows_a_in;
   logic [mme_pkg::DIM_REG_W-1:0] inner_len_ff, inner_len_in;
   logic [mme_pkg::DIM_REG_W-1:0] cols_b_ff, cols_b_in;

   logic [CNT_W-1:0] eff_rows, eff_inner, eff_cols;
   logic accept, in_store, idx_err;
   mme_pkg::opcode_type op;

   // sizes above MAX_DIM act as MAX_DIM
   always_comb begin
      eff_rows  = (int'(rows_a_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(rows_a_ff);
      eff_inner = (int'(inner_len_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(inner_len_ff);
      eff_cols  = (int'(cols_b_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(cols_b_ff);
   end

   assign op       = mme_pkg::opcode_type'(req_opcode);
   assign accept   = req_tvalid && req_tready;
   assign in_store = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign idx_err  = (int'(req_row) >= int'(eff_rows)) || (int'(req_col) >= int'(eff_cols));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rd_index   = cnt_ff[IDX_W-1:0];

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_len_in = inner_len_ff;
      cols_b_in    = cols_b_ff;
      if (csr_we) begin
         unique case (mme_pkg::csr_index_type'(csr_index))
            mme_pkg::CSR_ROWS_A:    rows_a_in    = csr_wdata;
            mme_pkg::CSR_INNER_LEN: inner_len_in = csr_wdata;
            mme_pkg::CSR_COLS_B:    cols_b_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  mme_pkg::OP_LOAD_A: cmd.wr_a = in_store;
                  mme_pkg::OP_LOAD_B: cmd.wr_b = in_store;
                  mme_pkg::OP_COMPUTE: begin
                     cmd.capture = 1'b1;
                     cmd.err     = idx_err;
                     cnt_in      = '0;
                     if (idx_err || eff_inner == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            cnt_in    = CNT_W'(cnt_ff + 1'b1);
            if (CNT_W'(cnt_ff + 1'b1) == eff_inner) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rows_a_ff    <= mme_pkg::DIM_RESET;
         inner_len_ff <= mme_pkg::DIM_RESET;
         cols_b_ff    <= mme_pkg::DIM_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_a_ff    <= rows_a_in;
         inner_len_ff <= inner_len_in;
         cols_b_ff    <= cols_b_in;
      end
   end

endmodule

// ----- src/mme_datapath.sv -----
// datapath: element stores, multiply-accumulate pipeline and result register
module mme_datapath #(
   parameter int MAX_DIM      = mme_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_BITS = mme_pkg::ELEMENT_BITS_DEFAULT,
   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mme_pkg::cmd_type                     cmd,
   input  logic [IDX_W-1:0]                     rd_index,
   output mme_pkg::status_type                  status,
   input  logic [mme_pkg::IDX_FIELD_W-1:0]      req_row,
   input  logic [mme_pkg::IDX_FIELD_W-1:0]      req_col,
   input  logic [mme_pkg::VALUE_W-1:0]          req_value,
   output logic [mme_pkg::IDX_FIELD_W-1:0]      rsp_row,
   output logic [mme_pkg::IDX_FIELD_W-1:0]      rsp_col,
   output logic [mme_pkg::SUM_W-1:0]            rsp_sum,
   output logic                                 rsp_err
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int EB    = ELEMENT_BITS;
   localparam int PW    = 2 * EB;
   localparam int EXT_W = ((PW > mme_pkg::SUM_W) ? PW : mme_pkg::SUM_W) + 1;

   logic [EB-1:0] mem_a [DEPTH];
   logic [EB-1:0] mem_b [DEPTH];

   logic [EB-1:0] elem;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

   logic [mme_pkg::IDX_FIELD_W-1:0] row_ff, col_ff;
   logic err_ff;
   logic signed [EB-1:0] a_q_ff, b_q_ff;
   logic rdv_ff, pv_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [mme_pkg::SUM_W-1:0] acc_ff, acc_sat;
   logic signed [EXT_W-1:0] sum_ext;

   logic [mme_pkg::IDX_FIELD_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [mme_pkg::SUM_W-1:0] rsp_sum_ff;
   logic rsp_err_ff;

   // narrow elements keep their low bits, wide ones sign-extend the value
   generate
      if (EB <= mme_pkg::VALUE_W) begin : g_narrow
         assign elem = req_value[EB-1:0];
      end else begin : g_wide
         assign elem = {{(EB - mme_pkg::VALUE_W){req_value[mme_pkg::VALUE_W-1]}}, req_value};
      end
   endgenerate

   assign wr_addr   = AW'(AW'(IDX_W'(req_row)) * AW'(MAX_DIM) + AW'(IDX_W'(req_col)));
   assign rd_addr_a = AW'(AW'(IDX_W'(row_ff)) * AW'(MAX_DIM) + AW'(rd_index));
   assign rd_addr_b = AW'(AW'(rd_index) * AW'(MAX_DIM) + AW'(IDX_W'(col_ff)));

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[wr_addr] <= elem;
      end
      if (cmd.wr_b) begin
         mem_b[wr_addr] <= elem;
      end
      if (cmd.rd_en) begin
         a_q_ff <= mem_a[rd_addr_a];
         b_q_ff <= mem_b[rd_addr_b];
      end
   end

   assign prod_in = a_q_ff * b_q_ff;
   assign sum_ext = EXT_W'(acc_ff) + EXT_W'(prod_ff);

   // clamp to the signed sum range after every term
   always_comb begin
      if (sum_ext > EXT_W'(mme_pkg::SUM_MAX)) begin
         acc_sat = mme_pkg::SUM_MAX;
      end else if (sum_ext < EXT_W'(mme_pkg::SUM_MIN)) begin
         acc_sat = mme_pkg::SUM_MIN;
      end else begin
         acc_sat = sum_ext[mme_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         pv_ff  <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_en;
         pv_ff  <= rdv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdv_ff) begin
         prod_ff <= prod_in;
      end
      if (cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
         err_ff <= cmd.err;
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_sat;
      end
      if (cmd.emit) begin
         rsp_row_ff <= row_ff;
         rsp_col_ff <= col_ff;
         rsp_sum_ff <= acc_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign status.busy = rdv_ff || pv_ff;

   assign rsp_row = rsp_row_ff;
   assign rsp_col = rsp_col_ff;
   assign rsp_sum = rsp_sum_ff;
   assign rsp_err = rsp_err_ff;

endmodule

// ----- src/matrix_multiply_engine_core.sv -----
// top level of the fixed-point matrix multiply engine
// Computes C = A * B one element at a time in signed fixed point. Load items
// (opcode 0 for A, 1 for B) write one Q8.8 element at row, col and leave
// the engine ready; loads with row or col at or beyond MAX_DIM are dropped. A
// compute item (opcode 2) returns result_row, result_col, the saturating
// Q20.16 dot product of A row and B column over inner_len terms, and
// index_error when row >= rows_a or col >= cols_b (sum then zero). A compute
// item walks the stored pairs through a single multiply-accumulate unit, one
// pair per cycle, behind a registered store read and a registered product,
// then waits for the output register to be free; an index error or a zero
// inner_len skips the multiply-accumulate. Opcode 3 is ignored. The next
// item is taken while a finished result waits in the output register. Size
// registers above MAX_DIM act as MAX_DIM and should be written only while the
// engine is idle. Store entries hold no defined value until loaded, so every
// entry a compute item reads must have been written first.
module matrix_multiply_engine_core #(
   parameter int MAX_DIM      = mme_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_BITS = mme_pkg::ELEMENT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // row[3:0], col[7:4], value[23:8]
   input  logic [1:0]                     req_tuser,  // opcode[1:0]
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,  // result_row[3:0], result_col[7:4],
                                                      // product_sum[43:8], zero fill above
   output logic [0:0]                     rsp_tuser,  // index_error[0]
   // size registers
   input  logic                           csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mme_pkg::DIM_REG_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   mme_pkg::cmd_type    cmd;
   mme_pkg::status_type status;
   logic [IDX_W-1:0]    rd_index;

   logic [mme_pkg::IDX_FIELD_W-1:0] rsp_row, rsp_col;
   logic [mme_pkg::SUM_W-1:0]       rsp_sum;
   logic                            rsp_err;

   // sequencing, size registers and result valid
   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .req_row    (req_tdata[3:0]),
      .req_col    (req_tdata[7:4]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .rd_index   (rd_index),
      .status     (status)
   );

   // stores, multiply-accumulate and result payload
   mme_datapath #(
      .MAX_DIM      (MAX_DIM),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_index  (rd_index),
      .status    (status),
      .req_row   (req_tdata[3:0]),
      .req_col   (req_tdata[7:4]),
      .req_value (req_tdata[23:8]),
      .rsp_row   (rsp_row),
      .rsp_col   (rsp_col),
      .rsp_sum   (rsp_sum),
      .rsp_err   (rsp_err)
   );

   // pack result fields, pad to whole bytes
   assign rsp_tdata = {4'b0000, rsp_sum, rsp_col, rsp_row};
   assign rsp_tuser = rsp_err;

endmodule
